// ----- rtl/fpa_pkg.sv -----
// Shared types and codes for the fit partition allocator.
package fpa_pkg;

	localparam int TOTAL_W    = 20;
	localparam int REQ_SIZE_W = 16;
	localparam int PIDX_W     = 4;
	localparam int FIT_MODE_W = 2;
	localparam int PARTS_W    = 5;
	localparam int CFG_DATA_W = 5;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
	localparam logic [PARTS_W-1:0] PARTS_RESET = 5'd16;

	// request types
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// result status
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_ALLOC = 2'd1;
	localparam logic [1:0] STAT_FAIL  = 2'd2;

	// placement policy
	localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

	// register indexes
	localparam logic CFG_FIT_MODE     = 1'b0;
	localparam logic CFG_PARTS_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic init;
		logic beat;
	} scan_ctl_t;

endpackage

// ----- rtl/fpa_table.sv -----
// Partition free-size table: synchronous memory with per-entry valid bits.
module fpa_table #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_WIDTH     = 16,
	localparam int IDX_W         = $clog2(NUM_PARTITIONS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [SIZE_WIDTH-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [SIZE_WIDTH-1:0] wr_data,
	input  logic                  clr_all
);

	logic [SIZE_WIDTH-1:0]     mem [NUM_PARTITIONS];
	logic [NUM_PARTITIONS-1:0] valid_q;
	logic [SIZE_WIDTH-1:0]     rd_q;
	logic                      rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// an entry never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ----- rtl/fpa_scan.sv -----
// Scan datapath: one entry per beat, keeps the pick and the exact free sum.
module fpa_scan #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_WIDTH     = 16,
	localparam int IDX_W         = $clog2(NUM_PARTITIONS),
	localparam int CMP_W         = (SIZE_WIDTH > fpa_pkg::REQ_SIZE_W) ?
	                               SIZE_WIDTH : fpa_pkg::REQ_SIZE_W,
	localparam int SUM_RAW       = CMP_W + $clog2(NUM_PARTITIONS),
	localparam int SUM_W         = ((SUM_RAW > fpa_pkg::TOTAL_W) ?
	                               SUM_RAW : fpa_pkg::TOTAL_W) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fpa_pkg::scan_ctl_t                ctl,
	input  logic [fpa_pkg::FIT_MODE_W-1:0]    fit_mode,
	input  logic [fpa_pkg::REQ_SIZE_W-1:0]    req_size,
	input  logic [SIZE_WIDTH-1:0]             rd_data,
	input  logic [IDX_W-1:0]                  rd_idx,
	output logic                              found,
	output logic [IDX_W-1:0]                  pick,
	output logic [SIZE_WIDTH-1:0]             pick_val,
	output logic [SUM_W-1:0]                  sum
);
	import fpa_pkg::*;

	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_WIDTH-1:0] best_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  fits;
	logic                  take;

	assign fits = CMP_W'(rd_data) >= CMP_W'(req_size);

	// ties keep the earlier, lower index
	always_comb begin
		take = 1'b0;
		if (ctl.beat && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (fit_mode)
					FIT_BEST:  take = rd_data < best_q;
					FIT_WORST: take = rd_data > best_q;
					default:   take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			sum_q <= '0;
		end else if (ctl.beat) begin
			sum_q <= sum_q + SUM_W'(rd_data);
		end
		if (take) begin
			pick_q <= rd_idx;
			best_q <= rd_data;
		end
	end

	assign found    = found_q;
	assign pick     = pick_q;
	assign pick_val = best_q;
	assign sum      = sum_q;

endmodule

// ----- rtl/fit_partition_allocator.sv -----
// Top level of the fit partition allocator: sequencer, totals and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_stall  | req_type, partition_index, req_size
//  out     | output    | out_valid / out_stall| status, chosen_index, left_in_partition,
//          |           |                      |   internal_frag_total, free_total
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A load writes its entry and then scans, an allocate scans, and a clear or an unused type
// goes straight to commit. A scan reads n entries, where n is min(partitions_in_use,
// NUM_PARTITIONS): the single table read port scans one entry a cycle, the scan drains
// through the table read register into the scan registers, then commit does the write-back
// and totals. The next beat is taken the cycle after the result loads.
// Reset empties the table at once through per-entry valid bits; no clearing pass.
// A result waits in its output register while out_stall is high; the next beat is
// taken meanwhile and its processing holds at commit until that register frees.
module fit_partition_allocator #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_WIDTH     = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic [fpa_pkg::PIDX_W-1:0]       partition_index,
	input  logic [fpa_pkg::REQ_SIZE_W-1:0]   req_size,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [fpa_pkg::PIDX_W-1:0]       chosen_index,
	output logic [fpa_pkg::REQ_SIZE_W-1:0]   left_in_partition,
	output logic [fpa_pkg::TOTAL_W-1:0]      internal_frag_total,
	output logic [fpa_pkg::TOTAL_W-1:0]      free_total,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fpa_pkg::*;

	localparam int IDX_W   = $clog2(NUM_PARTITIONS);
	localparam int CNT_W   = $clog2(NUM_PARTITIONS + 1);
	localparam int CMP_W   = (SIZE_WIDTH > REQ_SIZE_W) ? SIZE_WIDTH : REQ_SIZE_W;
	localparam int SUM_RAW = CMP_W + $clog2(NUM_PARTITIONS);
	localparam int SUM_W   = ((SUM_RAW > TOTAL_W) ? SUM_RAW : TOTAL_W) + 1;
	localparam int FRAG_W  = ((SIZE_WIDTH > TOTAL_W) ? SIZE_WIDTH : TOTAL_W) + 1;

	state_t                   state_q, state_d;
	logic [FIT_MODE_W-1:0]    fit_mode_q;
	logic [PARTS_W-1:0]       parts_q;
	logic [1:0]               type_q;
	logic [PIDX_W-1:0]        pidx_q;
	logic [REQ_SIZE_W-1:0]    size_q;
	logic [CNT_W-1:0]         rd_cnt_q;
	logic                     beat_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [TOTAL_W-1:0]       frag_q, free_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [PIDX_W-1:0]        chosen_q;
	logic [REQ_SIZE_W-1:0]    left_q;

	logic                     in_acc;
	logic                     out_free;
	logic [CNT_W-1:0]         n_act;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic                     load_wr;
	logic                     finish;
	logic                     scan_done;
	scan_ctl_t                scan_ctl;

	logic [SIZE_WIDTH-1:0]    rd_data;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [SIZE_WIDTH-1:0]    wr_data;
	logic                     clr_all;

	logic                     found;
	logic [IDX_W-1:0]         pick;
	logic [SIZE_WIDTH-1:0]    pick_val;
	logic [SUM_W-1:0]         sum;

	logic                     alloc_hit;
	logic [SIZE_WIDTH-1:0]    new_val;
	logic [SUM_W-1:0]         free_raw;
	logic [TOTAL_W-1:0]       free_sat;
	logic [FRAG_W-1:0]        frag_raw;
	logic [TOTAL_W-1:0]       frag_sat;
	logic [1:0]               res_status;
	logic [PIDX_W-1:0]        res_chosen;
	logic [REQ_SIZE_W-1:0]    res_left;
	logic [TOTAL_W-1:0]       frag_d, free_d;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign n_act    = (32'(parts_q) > 32'(NUM_PARTITIONS)) ?
	                  CNT_W'(NUM_PARTITIONS) : CNT_W'(parts_q);
	assign rd_addr  = rd_cnt_q[IDX_W-1:0];
	// last read issued and its data consumed
	assign scan_done = (rd_cnt_q == n_act) && !beat_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (req_type)
						REQ_LOAD:  state_d = ST_LOAD;
						REQ_ALLOC: state_d = ST_SCAN;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall      = 1'b1;
		rd_en         = 1'b0;
		load_wr       = 1'b0;
		finish        = 1'b0;
		scan_ctl.init = 1'b0;
		scan_ctl.beat = beat_s1;
		case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				scan_ctl.init = 1'b1;
			end
			ST_LOAD: begin
				scan_ctl.init = 1'b1;
				load_wr       = 32'(pidx_q) < 32'(NUM_PARTITIONS);
			end
			ST_SCAN: begin
				rd_en = rd_cnt_q < n_act;
			end
			ST_DONE: begin
				finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			beat_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (scan_ctl.init) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			beat_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_q <= req_type;
			pidx_q <= partition_index;
			size_q <= req_size;
		end
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			parts_q    <= PARTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIT_MODE:     fit_mode_q <= cfg_data[FIT_MODE_W-1:0];
				CFG_PARTS_IN_USE: parts_q    <= cfg_data[PARTS_W-1:0];
				default: ;
			endcase
		end
	end

	fpa_table #(
		.NUM_PARTITIONS (NUM_PARTITIONS),
		.SIZE_WIDTH     (SIZE_WIDTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clr_all (clr_all)
	);

	fpa_scan #(
		.NUM_PARTITIONS (NUM_PARTITIONS),
		.SIZE_WIDTH     (SIZE_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.fit_mode (fit_mode_q),
		.req_size (size_q),
		.rd_data  (rd_data),
		.rd_idx   (idx_s1),
		.found    (found),
		.pick     (pick),
		.pick_val (pick_val),
		.sum      (sum)
	);

	// commit: the pick held at least the request, so the differences cannot wrap
	assign alloc_hit = (type_q == REQ_ALLOC) && found;
	assign new_val   = pick_val - SIZE_WIDTH'(size_q);
	assign free_raw  = alloc_hit ? (sum - SUM_W'(size_q)) : sum;
	assign free_sat  = (free_raw > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(free_raw);
	assign frag_raw  = FRAG_W'(frag_q) + FRAG_W'(new_val);
	assign frag_sat  = (frag_raw > FRAG_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(frag_raw);

	assign wr_en   = load_wr || (finish && alloc_hit);
	assign wr_addr = (finish && alloc_hit) ? pick : IDX_W'(pidx_q);
	assign wr_data = (finish && alloc_hit) ? new_val : SIZE_WIDTH'(size_q);
	assign clr_all = finish && (type_q == REQ_CLEAR);

	always_comb begin
		res_status = STAT_DONE;
		res_chosen = '0;
		res_left   = '0;
		frag_d     = frag_q;
		free_d     = free_q;
		case (type_q)
			REQ_LOAD: begin
				free_d = free_sat;
			end
			REQ_ALLOC: begin
				free_d = free_sat;
				if (found) begin
					res_status = STAT_ALLOC;
					res_chosen = PIDX_W'(pick);
					res_left   = REQ_SIZE_W'(new_val);
					frag_d     = frag_sat;
				end else begin
					res_status = STAT_FAIL;
				end
			end
			REQ_CLEAR: begin
				frag_d = '0;
				free_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_q      <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				frag_q      <= frag_d;
				free_q      <= free_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= res_status;
			chosen_q <= res_chosen;
			left_q   <= res_left;
		end
	end

	// totals only move at commit, which waits for the result register to free
	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign chosen_index        = chosen_q;
	assign left_in_partition   = left_q;
	assign internal_frag_total = frag_q;
	assign free_total          = free_q;

endmodule

// ----- rtl/fpa_check.sv -----
// Port-level checks for the fit partition allocator, bound to the top level.
module fpa_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [3:0]  chosen_index,
	input logic [15:0] left_in_partition,
	input logic [19:0] internal_frag_total,
	input logic [19:0] free_total
);
	import fpa_pkg::*;

	// one item at a time: an accepted beat makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still in work");

	// index and leftover are only meaningful for a successful allocate
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_ALLOC) |-> (chosen_index == 4'd0)
			&& (left_in_partition == 16'd0))
		else $error("chosen index or leftover set without an allocation");

	// a stalled result keeps its valid and status, totals included
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(internal_frag_total) && $stable(free_total))
		else $error("stalled result beat changed");

endmodule

bind fit_partition_allocator fpa_check u_fpa_check (.*);
